>>> rtl/tfvs_pkg.sv
// Shared constants, widths and interface types of the thermal frame variance selector.
// Used by tfvs_ctrl, tfvs_dp and the top level; depends on nothing else.
package tfvs_pkg;

  localparam int PIXELS_PER_FRAME = 64;
  localparam int PAIR_COUNT = (PIXELS_PER_FRAME + 1) / 2;
  localparam int STORE_DEPTH = 2 * PIXELS_PER_FRAME;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int PIX_W = $clog2(PIXELS_PER_FRAME);
  localparam int PAIR_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int IDX_W = PAIR_W + 1;

  localparam int RAW_W = 12;
  localparam int MAG_W = 11;
  localparam int SIGN_BIT = 11;
  localparam int MAG_MAX = (1 << MAG_W) - 1;

  localparam longint unsigned SUM_MAX = longint'(PIXELS_PER_FRAME) * MAG_MAX;
  localparam longint unsigned SQ_MAX = SUM_MAX * MAG_MAX;
  localparam int SUM_W = $clog2(SUM_MAX + 1) + 1;
  localparam int ABS_W = SUM_W - 1;
  localparam int SQ_W = $clog2(SQ_MAX + 1);
  localparam int VAR_W = SQ_W + $clog2(PIXELS_PER_FRAME + 1);

  localparam int PAIR_OUT_W = 24;
  localparam int PAIR_IDX_W = 5;
  localparam int OUT_VAR_W = 34;
  localparam int WIDE_W = (VAR_W > OUT_VAR_W) ? VAR_W : OUT_VAR_W;
  localparam logic [OUT_VAR_W-1:0] OUT_VAR_MAX = {OUT_VAR_W{1'b1}};

  localparam int FPR_W = 8;
  localparam logic [FPR_W-1:0] FPR_RESET = 8'd36;
  localparam int CFG_DATA_W = 34;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAMES_PER_ROUND = 1'b0,
    REG_MIN_VARIANCE     = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic accept_pix;
    logic square;
    logic decide;
    logic rd_first;
    logic rd_second;
    logic load_out;
    logic pair_next;
  } tfvs_cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic emit;
    logic last_pair;
    logic out_done;
  } tfvs_sts_t;

endpackage

>>> rtl/tfvs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
module tfvs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tfvs_ctrl.sv
// Controller state machine: sequences pixel intake, the end-of-frame variance
// steps and the readout of the kept frame. Depends on tfvs_pkg.
module tfvs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pixel_valid_i,
  output logic                pixel_stall_o,
  input  tfvs_pkg::tfvs_sts_t sts_i,
  output tfvs_pkg::tfvs_cmd_t cmd_o
);
  import tfvs_pkg::*;

  typedef enum logic [2:0] {
    S_PIXEL,
    S_SQUARE,
    S_DECIDE,
    S_RD_A,
    S_RD_B,
    S_LOAD,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  logic   accept;

  assign accept = pixel_valid_i && !stall_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_PIXEL: begin
        if (accept && sts_i.last_pixel) begin
          state_d = S_SQUARE;
        end
      end
      S_SQUARE: state_d = S_DECIDE;
      S_DECIDE: state_d = sts_i.emit ? S_RD_A : S_PIXEL;
      S_RD_A:   state_d = S_RD_B;
      S_RD_B:   state_d = S_LOAD;
      S_LOAD:   state_d = S_OUT;
      S_OUT: begin
        if (sts_i.out_done) begin
          state_d = sts_i.last_pair ? S_PIXEL : S_RD_A;
        end
      end
      default: state_d = S_PIXEL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_PIXEL;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != S_PIXEL);
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept_pix = accept;
    cmd_o.square     = (state_q == S_SQUARE);
    cmd_o.decide     = (state_q == S_DECIDE);
    cmd_o.rd_first   = (state_q == S_RD_A);
    cmd_o.rd_second  = (state_q == S_RD_B);
    cmd_o.load_out   = (state_q == S_LOAD);
    cmd_o.pair_next  = (state_q == S_OUT) && sts_i.out_done;
  end

  assign pixel_stall_o = stall_q;

endmodule

>>> rtl/tfvs_dp.sv
// Datapath: configuration registers, frame accumulators, variance compare,
// ping-pong frame store and output register. Depends on tfvs_pkg and tfvs_ram.
module tfvs_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tfvs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tfvs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [tfvs_pkg::RAW_W-1:0]          pixel_raw_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [tfvs_pkg::PAIR_OUT_W-1:0]     packed_pair_o,
  output logic [tfvs_pkg::PAIR_IDX_W-1:0]     pair_index_o,
  output logic [tfvs_pkg::OUT_VAR_W-1:0]      best_variance_o,
  output logic                                last_of_round_o,
  input  tfvs_pkg::tfvs_cmd_t                 cmd_i,
  output tfvs_pkg::tfvs_sts_t                 sts_o
);
  import tfvs_pkg::*;

  logic [FPR_W-1:0]          fpr_q;
  logic [OUT_VAR_W-1:0]      minv_q;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SQ_W-1:0]           sq_q, sq_d;
  logic [PIX_W-1:0]          pix_cnt_q;
  logic [FPR_W-1:0]          frame_cnt_q;
  logic                      found_q;
  logic                      best_slot_q;
  logic [VAR_W-1:0]          best_q;
  logic [2*ABS_W-1:0]        ssq_q;
  logic [VAR_W-1:0]          scaled_q;
  logic [PAIR_W-1:0]         pair_q;
  logic [RAW_W-1:0]          first_q;
  logic                      out_valid_q;
  logic [PAIR_OUT_W-1:0]     packed_q;
  logic [PAIR_IDX_W-1:0]     pair_idx_q;
  logic [OUT_VAR_W-1:0]      best_out_q;
  logic                      last_q;

  logic [MAG_W-1:0]          mag;
  logic [2*MAG_W-1:0]        mag_sq;
  logic [ABS_W-1:0]          abs_sum;
  logic [VAR_W-1:0]          var_now;
  logic [WIDE_W-1:0]         var_wide, thr_wide, best_wide;
  logic                      keep;
  logic [FPR_W-1:0]          frame_cnt_next, limit;
  logic                      round_end;
  logic [ADDR_W-1:0]         waddr, raddr, rbase;
  logic [IDX_W-1:0]          first_idx, second_idx;
  logic                      has_second;
  logic [RAW_W-1:0]          rdata;
  logic [OUT_VAR_W-1:0]      var_sat;
  logic                      last_pair;

  // Sign-magnitude pixel into the signed and squared accumulators.
  assign mag    = pixel_raw_i[MAG_W-1:0];
  assign mag_sq = mag * mag;
  assign sum_d  = pixel_raw_i[SIGN_BIT] ? sum_q - SUM_W'(signed'({1'b0, mag}))
                                        : sum_q + SUM_W'(signed'({1'b0, mag}));
  assign sq_d   = sq_q + SQ_W'(mag_sq);

  assign abs_sum = sum_q[SUM_W-1] ? ABS_W'(-sum_q) : ABS_W'(sum_q);

  assign var_now  = scaled_q - VAR_W'(ssq_q);
  assign var_wide = WIDE_W'(var_now);
  assign thr_wide = found_q ? WIDE_W'(best_q) : WIDE_W'(minv_q);
  assign keep     = var_wide > thr_wide;

  assign frame_cnt_next = frame_cnt_q + 1'b1;
  assign limit          = (fpr_q == '0) ? FPR_W'(1) : fpr_q;
  assign round_end      = (frame_cnt_next == '0) || (frame_cnt_next >= limit);

  assign best_wide = WIDE_W'(best_q);
  assign var_sat   = (best_wide > WIDE_W'(OUT_VAR_MAX)) ? OUT_VAR_MAX
                                                        : best_wide[OUT_VAR_W-1:0];

  assign waddr = ADDR_W'(pix_cnt_q) + (best_slot_q ? '0 : ADDR_W'(PIXELS_PER_FRAME));
  assign rbase = best_slot_q ? ADDR_W'(PIXELS_PER_FRAME) : '0;

  assign first_idx  = {pair_q, 1'b0};
  assign second_idx = {pair_q, 1'b1};
  assign has_second = (IDX_W+1)'(second_idx) < (IDX_W+1)'(PIXELS_PER_FRAME);
  assign raddr      = rbase + (cmd_i.rd_second ? ADDR_W'(second_idx) : ADDR_W'(first_idx));
  assign last_pair  = (pair_q == PAIR_W'(PAIR_COUNT - 1));

  tfvs_ram #(
    .WIDTH(RAW_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept_pix),
    .waddr_i(waddr),
    .wdata_i(pixel_raw_i),
    .re_i   (cmd_i.rd_first || cmd_i.rd_second),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpr_q       <= FPR_RESET;
      minv_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      pix_cnt_q   <= '0;
      frame_cnt_q <= '0;
      found_q     <= 1'b0;
      best_slot_q <= 1'b0;
      best_q      <= '0;
      pair_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_FRAMES_PER_ROUND: fpr_q  <= cfg_data_i[FPR_W-1:0];
          REG_MIN_VARIANCE:     minv_q <= cfg_data_i[OUT_VAR_W-1:0];
          default:              fpr_q  <= fpr_q;
        endcase
      end
      if (cmd_i.accept_pix) begin
        sum_q     <= sum_d;
        sq_q      <= sq_d;
        pix_cnt_q <= pix_cnt_q + 1'b1;
      end
      if (cmd_i.decide) begin
        sum_q     <= '0;
        sq_q      <= '0;
        pix_cnt_q <= '0;
        pair_q    <= '0;
        if (keep) begin
          best_q      <= var_now;
          best_slot_q <= ~best_slot_q;
        end
        if (round_end) begin
          frame_cnt_q <= '0;
          found_q     <= 1'b0;
        end else begin
          frame_cnt_q <= frame_cnt_next;
          found_q     <= found_q || keep;
        end
      end
      if (cmd_i.pair_next) begin
        pair_q <= pair_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.square) begin
      ssq_q    <= abs_sum * abs_sum;
      scaled_q <= VAR_W'(sq_q) * VAR_W'(PIXELS_PER_FRAME);
    end
    if (cmd_i.rd_second) begin
      first_q <= rdata;
    end
    if (cmd_i.load_out) begin
      packed_q   <= {first_q, has_second ? rdata : RAW_W'(0)};
      pair_idx_q <= PAIR_IDX_W'(pair_q);
      best_out_q <= var_sat;
      last_q     <= last_pair;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.last_pixel = (pix_cnt_q == PIX_W'(PIXELS_PER_FRAME - 1));
    sts_o.emit       = round_end && (found_q || keep);
    sts_o.last_pair  = last_pair;
    sts_o.out_done   = out_valid_q && !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign packed_pair_o   = packed_q;
  assign pair_index_o    = pair_idx_q;
  assign best_variance_o = best_out_q;
  assign last_of_round_o = last_q;

`ifndef SYNTH
  a_no_pixel_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept_pix |-> !out_valid_q)
    else $error("Pixel accepted while a result is pending.");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |=> (pix_cnt_q == '0) && (sum_q == '0) && (sq_q == '0))
    else $error("Accumulators not cleared after the frame decision.");

  a_found_clear_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !found_q)
    else $error("Round state not cleared before readout.");

  a_read_between_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd_first || cmd_i.rd_second) |-> (pix_cnt_q == '0))
    else $error("Frame store read while a frame is being received.");
`endif

endmodule

>>> rtl/thermal_frame_variance_selector.sv
// Thermal frame variance selector, top level.
// Instantiates tfvs_ctrl and tfvs_dp; depends on tfvs_pkg.
//
// Pixels arrive on the pixel channel (pixel_valid_i, pixel_stall_o), one per
// cycle while the block is collecting a frame. After the last pixel of a frame
// the input is stalled while the scaled variance is formed and compared, in
// the square and the compare steps of the end-of-frame sequence.
// At the end of a round in which a frame was kept, the input stays stalled
// while the kept frame is read out of the single-read-port frame store. Each
// pixel pair takes two reads, a load and an output step, and the next pair is
// not read until the previous one has left, for all 32 pairs of the round; the
// first pair is offered after the square, compare, read and load steps that
// follow the last pixel of the round. Each result transaction moves on
// out_valid_o and out_stall_i; while out_stall_i is high the result holds and
// readout pauses. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write it only while the block is idle, since the
// block itself does not enforce this. Reset clears all control state, sets
// frames_per_round to 36 and min_variance to 0; no clearing pass is needed.
module thermal_frame_variance_selector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tfvs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tfvs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                pixel_valid_i,
  output logic                                pixel_stall_o,
  input  logic [tfvs_pkg::RAW_W-1:0]          pixel_raw_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tfvs_pkg::PAIR_OUT_W-1:0]     packed_pair_o,
  output logic [tfvs_pkg::PAIR_IDX_W-1:0]     pair_index_o,
  output logic [tfvs_pkg::OUT_VAR_W-1:0]      best_variance_o,
  output logic                                last_of_round_o
);
  import tfvs_pkg::*;

  tfvs_cmd_t cmd;
  tfvs_sts_t sts;

  tfvs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_valid_i(pixel_valid_i),
    .pixel_stall_o(pixel_stall_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  tfvs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_raw_i    (pixel_raw_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .packed_pair_o  (packed_pair_o),
    .pair_index_o   (pair_index_o),
    .best_variance_o(best_variance_o),
    .last_of_round_o(last_of_round_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
